>>> hdl/bbpf_pkg.sv
// Shared types and constants for the bar and beat position finder.
// Used by the top level, the divider and the engine; depends on nothing else.
package bbpf_pkg;

    localparam int POS_W             = 48;
    localparam int SIG_W             = 8;
    localparam int BAR_W             = 40;
    localparam int FRAC_OUT_W        = 16;
    localparam int PROD_W            = POS_W + SIG_W;
    localparam int DIV_W             = PROD_W + SIG_W;
    localparam int STEP_W            = 7;
    localparam int CFG_W             = 5;
    localparam int WORD_W            = POS_W + 2 * SIG_W;
    localparam int DEF_TABLE_DEPTH   = 16;
    localparam int DEF_FRACTION_BITS = 16;

    localparam logic [POS_W-1:0] POS_BIAS    = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [BAR_W-1:0] BAR_MAX     = {BAR_W{1'b1}};
    localparam logic [SIG_W-1:0] DEFAULT_SIG = SIG_W'(4);

    typedef enum logic [1:0] {
        ST_QUERY_OK  = 2'd0,
        ST_WRITE_OK  = 2'd1,
        ST_WRITE_REJ = 2'd2
    } status_t;

endpackage

>>> hdl/bar_beat_position_finder.sv
// A write request passes through the S_DONE state into the output registers and waits there
// while the output stalls. A query scans the table (skipped with fewer than two entries),
// runs the shared bit-serial divider once per entry before the one found, then twice more.
// Throughput: one request at a time; the next is taken once the result is staged.
// Reset clears control state and the entry count; the table RAM is not cleared.
// Depends on bbpf_pkg, bbpf_ram and bbpf_engine.
module bar_beat_position_finder #(
    parameter int TABLE_DEPTH   = bbpf_pkg::DEF_TABLE_DEPTH,
    parameter int FRACTION_BITS = bbpf_pkg::DEF_FRACTION_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [bbpf_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               kind,
    input  logic signed [bbpf_pkg::POS_W-1:0]  position,
    input  logic [3:0]                         entry_slot,
    input  logic [bbpf_pkg::SIG_W-1:0]         entry_beats_per_bar,
    input  logic [bbpf_pkg::SIG_W-1:0]         entry_beat_unit,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [bbpf_pkg::BAR_W-1:0]         bar_number,
    output logic [bbpf_pkg::SIG_W-1:0]         beat_number,
    output logic [bbpf_pkg::FRAC_OUT_W-1:0]    beat_fraction,
    output logic [bbpf_pkg::SIG_W-1:0]         sig_beats_per_bar,
    output logic [bbpf_pkg::SIG_W-1:0]         sig_beat_unit,
    output logic signed [bbpf_pkg::POS_W-1:0]  bar_begin,
    output logic [1:0]                         status
);
    import bbpf_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [CFG_W-1:0]  entries_reg;
    logic [CW-1:0]     entries_eff;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            entries_reg <= cfg_wr_data;
        end
    end

    // A count beyond the table depth is held at the depth.
    assign entries_eff = (32'(entries_reg) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                         : CW'(entries_reg);

    bbpf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bbpf_engine #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_engine (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .kind                (kind),
        .position            (position),
        .entry_slot          (entry_slot),
        .entry_beats_per_bar (entry_beats_per_bar),
        .entry_beat_unit     (entry_beat_unit),
        .entry_count         (entries_eff),
        .ram_we              (ram_we),
        .ram_waddr           (ram_waddr),
        .ram_wdata           (ram_wdata),
        .ram_raddr           (ram_raddr),
        .ram_rdata           (ram_rdata),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .bar_number          (bar_number),
        .beat_number         (beat_number),
        .beat_fraction       (beat_fraction),
        .sig_beats_per_bar   (sig_beats_per_bar),
        .sig_beat_unit       (sig_beat_unit),
        .bar_begin           (bar_begin),
        .status              (status)
    );

`ifndef SYNTHESIS
    a_table_write_on_request: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (in_valid && !in_stall && kind))
        else $error("table written without an accepted write request");

    a_query_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !kind) |=> in_stall)
        else $error("query did not occupy the sequencer");

    a_query_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_QUERY_OK) |->
        (beat_number != '0 && sig_beats_per_bar != '0 && sig_beat_unit != '0))
        else $error("query result carries a zero beat or signature");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (status <= ST_WRITE_REJ))
        else $error("undefined status code on a new result");
`endif

endmodule

>>> hdl/bbpf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module bbpf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/bbpf_div.sv
// Restoring divider, one quotient bit per cycle, divisor of SIG_W bits.
// Depends on bbpf_pkg for widths. The dividend arrives left-aligned.
module bbpf_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bbpf_pkg::DIV_W-1:0]    dividend,
    input  logic [bbpf_pkg::SIG_W-1:0]    divisor,
    input  logic [bbpf_pkg::STEP_W-1:0]   steps,
    output logic                          done,
    output logic [bbpf_pkg::DIV_W-1:0]    quotient,
    output logic [bbpf_pkg::SIG_W-1:0]    remainder
);
    import bbpf_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [SIG_W-1:0]  rem_reg;
    logic [SIG_W-1:0]  dsr_reg;

    logic [SIG_W:0]    trial;
    logic              fits;
    logic [SIG_W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DIV_W-1]};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = fits ? SIG_W'(trial - {1'b0, dsr_reg}) : trial[SIG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/bbpf_engine.sv
// Request sequencer: table writes; for queries a table scan, bar walk over earlier entries, final split.
// Depends on bbpf_pkg and instantiates bbpf_div; the table RAM sits outside.
module bbpf_engine #(
    parameter int TABLE_DEPTH   = bbpf_pkg::DEF_TABLE_DEPTH,
    parameter int FRACTION_BITS = bbpf_pkg::DEF_FRACTION_BITS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic                                     kind,
    input  logic signed [bbpf_pkg::POS_W-1:0]        position,
    input  logic [3:0]                               entry_slot,
    input  logic [bbpf_pkg::SIG_W-1:0]               entry_beats_per_bar,
    input  logic [bbpf_pkg::SIG_W-1:0]               entry_beat_unit,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]         entry_count,
    output logic                                     ram_we,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_waddr,
    output logic [bbpf_pkg::WORD_W-1:0]              ram_wdata,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_raddr,
    input  logic [bbpf_pkg::WORD_W-1:0]              ram_rdata,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic [bbpf_pkg::BAR_W-1:0]               bar_number,
    output logic [bbpf_pkg::SIG_W-1:0]               beat_number,
    output logic [bbpf_pkg::FRAC_OUT_W-1:0]          beat_fraction,
    output logic [bbpf_pkg::SIG_W-1:0]               sig_beats_per_bar,
    output logic [bbpf_pkg::SIG_W-1:0]               sig_beat_unit,
    output logic signed [bbpf_pkg::POS_W-1:0]        bar_begin,
    output logic [1:0]                               status
);
    import bbpf_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int K  = FRACTION_BITS + 2;
    localparam int QW = PROD_W - K;
    localparam int FW = K + FRAC_OUT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_WALK_RD,
        S_WALK_GET0,
        S_WALK_GET1,
        S_WALK_MUL,
        S_WALK_DIV,
        S_FIN_RD,
        S_FIN_GET,
        S_FIN_OFF,
        S_FIN_MUL,
        S_FIN_DIV,
        S_BEG_MUL,
        S_BEG_DIV,
        S_DONE
    } state_t;

    function automatic logic [SIG_W-1:0] at_least_one(input logic [SIG_W-1:0] v);
        return (v == '0) ? SIG_W'(1) : v;
    endfunction

    function automatic logic [BAR_W-1:0] sat_add(input logic [BAR_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {{(POS_W+1-BAR_W){1'b0}}, a} + {1'b0, b};
        return (s > {{(POS_W+1-BAR_W){1'b0}}, BAR_MAX}) ? BAR_MAX : s[BAR_W-1:0];
    endfunction

    state_t            state_reg;
    logic [POS_W-1:0]  pos_b_reg;
    logic [CW-1:0]     n_reg;
    logic [CW-1:0]     i_reg;
    logic [CW-1:0]     idx_reg;
    logic [POS_W-1:0]  s0_reg;
    logic [POS_W-1:0]  span_reg;
    logic [POS_W-1:0]  off_reg;
    logic [SIG_W-1:0]  wn_reg;
    logic [SIG_W-1:0]  wd_reg;
    logic [POS_W-1:0]  sb_reg;
    logic [SIG_W-1:0]  num_reg;
    logic [SIG_W-1:0]  den_reg;
    logic              low_nz_reg;
    logic [BAR_W-1:0]  prior_reg;
    logic [QW-1:0]     bars_reg;
    logic              div_start_reg;
    logic [DIV_W-1:0]  div_dvd_reg;
    logic [SIG_W-1:0]  div_dsr_reg;
    logic [STEP_W-1:0] div_steps_reg;
    logic [BAR_W-1:0]  res_bar_reg;
    logic [SIG_W-1:0]  res_beat_reg;
    logic [FRAC_OUT_W-1:0] res_frac_reg;
    logic [SIG_W-1:0]  res_num_reg;
    logic [SIG_W-1:0]  res_den_reg;
    logic [POS_W-1:0]  res_beg_reg;
    status_t           res_status_reg;
    logic              out_valid_reg;
    logic [BAR_W-1:0]  bar_number_reg;
    logic [SIG_W-1:0]  beat_number_reg;
    logic [FRAC_OUT_W-1:0] beat_fraction_reg;
    logic [SIG_W-1:0]  sig_num_reg;
    logic [SIG_W-1:0]  sig_den_reg;
    logic [POS_W-1:0]  bar_begin_reg;
    status_t           status_reg;

    logic              accept;
    logic              write_ok;
    logic [POS_W-1:0]  rd_start;
    logic [POS_W-1:0]  rd_bstart;
    logic [SIG_W-1:0]  rd_num;
    logic [SIG_W-1:0]  rd_den;
    logic [CW-1:0]     i_plus;
    logic [CW-1:0]     idx_sel;
    logic [POS_W-1:0]  mult_a;
    logic [SIG_W-1:0]  mult_b;
    logic [PROD_W-1:0] prod_c;
    logic [FW-1:0]     frac_wide;
    logic [POS_W-1:0]  sum_beg;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;
    logic [SIG_W-1:0]  div_rem;
    logic              out_free;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign write_ok = (entry_beats_per_bar != '0) && (entry_beat_unit != '0)
                      && (32'(entry_slot) < TABLE_DEPTH);

    assign ram_we    = accept && kind && write_ok;
    assign ram_waddr = AW'(entry_slot);
    assign ram_wdata = {position, entry_beats_per_bar, entry_beat_unit};

    assign rd_start  = ram_rdata[WORD_W-1 -: POS_W];
    assign rd_num    = ram_rdata[2*SIG_W-1 -: SIG_W];
    assign rd_den    = ram_rdata[SIG_W-1:0];
    assign rd_bstart = {~rd_start[POS_W-1], rd_start[POS_W-2:0]};
    assign i_plus    = CW'(i_reg + 1'b1);
    assign idx_sel   = (rd_bstart <= pos_b_reg) ? i_reg : idx_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign sum_beg   = sb_reg + div_quo[POS_W-1:0];

    always_comb
    begin
        unique case (state_reg)
            S_WALK_GET0: ram_raddr = i_plus[AW-1:0];
            S_FIN_RD:    ram_raddr = idx_reg[AW-1:0];
            default:     ram_raddr = i_reg[AW-1:0];
        endcase
    end

    // One shared 48 by 8 multiplier feeds every divider request.
    always_comb
    begin
        unique case (state_reg)
            S_WALK_MUL:
            begin
                mult_a = span_reg;
                mult_b = wd_reg;
            end
            S_BEG_MUL:
            begin
                mult_a = POS_W'(bars_reg);
                mult_b = num_reg;
            end
            default:
            begin
                mult_a = off_reg;
                mult_b = den_reg;
            end
        endcase
        prod_c    = mult_a * mult_b;
        frac_wide = {prod_c[K-1:0], {FRAC_OUT_W{1'b0}}};
    end

    bbpf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (div_dvd_reg),
        .divisor   (div_dsr_reg),
        .steps     (div_steps_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            pos_b_reg         <= '0;
            n_reg             <= '0;
            i_reg             <= '0;
            idx_reg           <= '0;
            s0_reg            <= '0;
            span_reg          <= '0;
            off_reg           <= '0;
            wn_reg            <= '0;
            wd_reg            <= '0;
            sb_reg            <= '0;
            num_reg           <= '0;
            den_reg           <= '0;
            low_nz_reg        <= 1'b0;
            prior_reg         <= '0;
            bars_reg          <= '0;
            div_start_reg     <= 1'b0;
            div_dvd_reg       <= '0;
            div_dsr_reg       <= '0;
            div_steps_reg     <= '0;
            res_bar_reg       <= '0;
            res_beat_reg      <= '0;
            res_frac_reg      <= '0;
            res_num_reg       <= '0;
            res_den_reg       <= '0;
            res_beg_reg       <= '0;
            res_status_reg    <= ST_QUERY_OK;
            out_valid_reg     <= 1'b0;
            bar_number_reg    <= '0;
            beat_number_reg   <= '0;
            beat_fraction_reg <= '0;
            sig_num_reg       <= '0;
            sig_den_reg       <= '0;
            bar_begin_reg     <= '0;
            status_reg        <= ST_QUERY_OK;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        pos_b_reg <= {~position[POS_W-1], position[POS_W-2:0]};
                        n_reg     <= entry_count;
                        prior_reg <= '0;
                        idx_reg   <= '0;
                        i_reg     <= CW'(1);
                        s0_reg    <= POS_BIAS;
                        if (kind)
                        begin
                            res_bar_reg    <= '0;
                            res_beat_reg   <= '0;
                            res_frac_reg   <= '0;
                            res_num_reg    <= '0;
                            res_den_reg    <= '0;
                            res_beg_reg    <= '0;
                            res_status_reg <= write_ok ? ST_WRITE_OK : ST_WRITE_REJ;
                            state_reg      <= S_DONE;
                        end
                        else if (entry_count == '0)
                        begin
                            // Empty table: plain four four from position zero.
                            sb_reg    <= POS_BIAS;
                            num_reg   <= DEFAULT_SIG;
                            den_reg   <= DEFAULT_SIG;
                            state_reg <= S_FIN_OFF;
                        end
                        else if (entry_count == CW'(1))
                        begin
                            state_reg <= S_FIN_RD;
                        end
                        else
                        begin
                            state_reg <= S_SCAN_RD;
                        end
                    end
                end

                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CMP;
                end

                // Every entry from index one up to below the count is checked, so an unsorted table
                // still picks the highest matching index; entry zero is taken when none matches.
                S_SCAN_CMP:
                begin
                    idx_reg <= idx_sel;
                    if (i_plus == n_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= (idx_sel == '0) ? S_FIN_RD : S_WALK_RD;
                    end
                    else
                    begin
                        i_reg     <= i_plus;
                        state_reg <= S_SCAN_RD;
                    end
                end

                S_WALK_RD:
                begin
                    state_reg <= S_WALK_GET0;
                end

                S_WALK_GET0:
                begin
                    wn_reg    <= at_least_one(rd_num);
                    wd_reg    <= at_least_one(rd_den);
                    state_reg <= S_WALK_GET1;
                end

                S_WALK_GET1:
                begin
                    span_reg  <= (rd_bstart > s0_reg) ? rd_bstart - s0_reg : '0;
                    s0_reg    <= rd_bstart;
                    state_reg <= S_WALK_MUL;
                end

                S_WALK_MUL:
                begin
                    div_start_reg <= 1'b1;
                    div_dvd_reg   <= {prod_c[PROD_W-1:K], {(DIV_W-QW){1'b0}}};
                    div_dsr_reg   <= wn_reg;
                    div_steps_reg <= STEP_W'(QW);
                    low_nz_reg    <= |prod_c[K-1:0];
                    state_reg     <= S_WALK_DIV;
                end

                // A partial bar before a change counts as a whole bar.
                S_WALK_DIV:
                begin
                    if (div_done)
                    begin
                        prior_reg <= sat_add(prior_reg,
                                             POS_W'(div_quo[QW-1:0])
                                             + POS_W'((div_rem != '0) || low_nz_reg));
                        i_reg     <= i_plus;
                        state_reg <= (i_plus == idx_reg) ? S_FIN_RD : S_WALK_RD;
                    end
                end

                S_FIN_RD:
                begin
                    state_reg <= S_FIN_GET;
                end

                S_FIN_GET:
                begin
                    sb_reg    <= (idx_reg == '0) ? POS_BIAS : rd_bstart;
                    num_reg   <= at_least_one(rd_num);
                    den_reg   <= at_least_one(rd_den);
                    state_reg <= S_FIN_OFF;
                end

                S_FIN_OFF:
                begin
                    off_reg   <= (pos_b_reg > sb_reg) ? pos_b_reg - sb_reg : '0;
                    state_reg <= S_FIN_MUL;
                end

                S_FIN_MUL:
                begin
                    div_start_reg <= 1'b1;
                    div_dvd_reg   <= {prod_c[PROD_W-1:K], {(DIV_W-QW){1'b0}}};
                    div_dsr_reg   <= num_reg;
                    div_steps_reg <= STEP_W'(QW);
                    res_frac_reg  <= frac_wide[FW-1 -: FRAC_OUT_W];
                    state_reg     <= S_FIN_DIV;
                end

                S_FIN_DIV:
                begin
                    if (div_done)
                    begin
                        bars_reg     <= div_quo[QW-1:0];
                        res_beat_reg <= SIG_W'(div_rem + 1'b1);
                        state_reg    <= S_BEG_MUL;
                    end
                end

                S_BEG_MUL:
                begin
                    div_start_reg <= 1'b1;
                    div_dvd_reg   <= {prod_c[QW+SIG_W-1:0], {K{1'b0}}};
                    div_dsr_reg   <= den_reg;
                    div_steps_reg <= STEP_W'(DIV_W);
                    state_reg     <= S_BEG_DIV;
                end

                S_BEG_DIV:
                begin
                    if (div_done)
                    begin
                        res_beg_reg    <= {~sum_beg[POS_W-1], sum_beg[POS_W-2:0]};
                        res_bar_reg    <= sat_add(prior_reg, POS_W'(bars_reg));
                        res_num_reg    <= num_reg;
                        res_den_reg    <= den_reg;
                        res_status_reg <= ST_QUERY_OK;
                        state_reg      <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        bar_number_reg    <= res_bar_reg;
                        beat_number_reg   <= res_beat_reg;
                        beat_fraction_reg <= res_frac_reg;
                        sig_num_reg       <= res_num_reg;
                        sig_den_reg       <= res_den_reg;
                        bar_begin_reg     <= res_beg_reg;
                        status_reg        <= res_status_reg;
                        state_reg         <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign bar_number        = bar_number_reg;
    assign beat_number       = beat_number_reg;
    assign beat_fraction     = beat_fraction_reg;
    assign sig_beats_per_bar = sig_num_reg;
    assign sig_beat_unit     = sig_den_reg;
    assign bar_begin         = bar_begin_reg;
    assign status            = status_reg;

endmodule
